// ===== design/ctw_pkg.sv =====
// ----------------------------------------------------------------------------
// ctw_pkg: shared types and constants for the connection timing wheel
// Field widths, request codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ctw_pkg;

	localparam int WHEEL_SIZE_DEF = 64;
	localparam int MAX_CONN_DEF   = 64;

	localparam int REQ_W      = 3;
	localparam int ID_W       = 6;
	localparam int SLOT_IN_W  = 6;
	localparam int TMO_W      = 16;
	localparam int SLOT_OUT_W = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD  = 3'd0,
		REQ_GET  = 3'd1,
		REQ_DEL  = 3'd2,
		REQ_UPD  = 3'd3,
		REQ_TICK = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_EVAL,
		ST_WR2,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic eval;
		logic wr2;
		logic emit;
	} ctw_cmd_t;

	typedef struct packed {
		logic out_free;
		logic is_tick;
		logic mem_empty;
		logic need_wr2;
		logic scan_last;
	} ctw_stat_t;

endpackage

// ===== design/ctw_if.sv =====
// ----------------------------------------------------------------------------
// ctw_if: request and response channels of the connection timing wheel
// Valid/ready channels; a transaction completes when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface ctw_req_if import ctw_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [REQ_W-1:0]     req_type;
	logic [ID_W-1:0]      conn_id;
	logic [SLOT_IN_W-1:0] slot_in;
	logic [TMO_W-1:0]     timeout_secs;

	modport source (output valid, req_type, conn_id, slot_in, timeout_secs, input ready);
	modport sink (input valid, req_type, conn_id, slot_in, timeout_secs, output ready);
endinterface

interface ctw_rsp_if import ctw_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  status;
	logic [SLOT_OUT_W-1:0] slot_out;
	logic [ID_W-1:0]       expired_id;
	logic                  expired_valid;
	logic                  last;

	modport source (output valid, status, slot_out, expired_id, expired_valid, last,
		input ready);
	modport sink (input valid, status, slot_out, expired_id, expired_valid, last,
		output ready);
endinterface

// ===== design/connection_timing_wheel.sv =====
// ----------------------------------------------------------------------------
// connection_timing_wheel: single-level timing wheel for connection timeouts
// Requests add, look up, delete or move connection ids in wheel slots; a tick
// advances the hand and reports every id held by the slot it lands on.
// ----------------------------------------------------------------------------
// Usage:
//   req: one transaction per request (type, id, slot, timeout). rsp: one
//   transaction per result; the last result of a request has last set.
//   A request is taken only while the block is idle, so a new request waits
//   until the last one is finished. An update that moves the id makes two
//   writes through the single bitmap write port. A tick gives one result per
//   expired id (at least one result), one id per cycle from the slot scan
//   while the response register is free.
//   The first result is registered in the evaluation state after load and
//   slot calculation, or in the first scan step for a tick that expires ids.
//   The response register holds a result until rsp.ready; while it is full
//   the sequencer waits and the next result is not produced, but a new
//   request is still taken once the previous one is finished.
//   Reset clears the hand and marks every slot empty at once through
//   per-slot valid bits; the block is ready right after reset.
// ----------------------------------------------------------------------------
module connection_timing_wheel import ctw_pkg::*; #(
	parameter int WHEEL_SIZE = WHEEL_SIZE_DEF,
	parameter int MAX_CONN   = MAX_CONN_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ctw_req_if.sink   req,
	ctw_rsp_if.source rsp
);

	ctw_cmd_t  cmd;
	ctw_stat_t stat;
	logic      in_ready;

	ctw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ctw_dp #(
		.WHEEL_SIZE (WHEEL_SIZE),
		.MAX_CONN   (MAX_CONN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req.req_type),
		.conn_id       (req.conn_id),
		.slot_in       (req.slot_in),
		.timeout_secs  (req.timeout_secs),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.status        (rsp.status),
		.slot_out      (rsp.slot_out),
		.expired_id    (rsp.expired_id),
		.expired_valid (rsp.expired_valid),
		.last          (rsp.last)
	);

	assign req.ready = in_ready;

endmodule

// ===== design/ctw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctw_ctrl: sequencer of the connection timing wheel
// Steps one request through load, slot address calculation, evaluation,
// an optional second write and the expired-id scan of a tick.
// ----------------------------------------------------------------------------
module ctw_ctrl import ctw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctw_stat_t stat,
	output ctw_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_EVAL;
			end
			ST_EVAL: begin
				// wait for the output register before committing
				if (stat.out_free) begin
					cmd.eval = 1'b1;
					if (stat.is_tick && !stat.mem_empty) begin
						state_d = ST_SCAN;
					end else if (stat.need_wr2) begin
						state_d = ST_WR2;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_WR2: begin
				cmd.wr2 = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.scan_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/ctw_dp.sv =====
// ----------------------------------------------------------------------------
// ctw_dp: datapath of the connection timing wheel
// Slot bitmap memory with per-slot valid bits, hand register, target slot
// arithmetic, expired-id scan and the registered response.
// ----------------------------------------------------------------------------
module ctw_dp import ctw_pkg::*; #(
	parameter int WHEEL_SIZE = WHEEL_SIZE_DEF,
	parameter int MAX_CONN   = MAX_CONN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctw_cmd_t              cmd,
	output ctw_stat_t             stat,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [ID_W-1:0]       conn_id,
	input  logic [SLOT_IN_W-1:0]  slot_in,
	input  logic [TMO_W-1:0]      timeout_secs,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  status,
	output logic [SLOT_OUT_W-1:0] slot_out,
	output logic [ID_W-1:0]       expired_id,
	output logic                  expired_valid,
	output logic                  last
);

	localparam int HAND_W = $clog2(WHEEL_SIZE);
	localparam int REM_W  = HAND_W + 2;
	localparam int RECIP  = 65536 / WHEEL_SIZE;
	localparam int QW     = 16;
	localparam int PW     = QW + 10;

	function automatic logic [ID_W-1:0] lowest_id(input logic [63:0] m);
		logic [63:0]     low;
		logic [ID_W-1:0] idx;
		low = m & (~m + 64'd1);
		idx = '0;
		for (int i = 0; i < 64; i++) begin
			if (low[i]) begin
				idx = idx | ID_W'(i);
			end
		end
		return idx;
	endfunction

	// slot bitmaps
	logic [MAX_CONN-1:0] mem [WHEEL_SIZE];
	logic [WHEEL_SIZE-1:0] vld_q;

	// request registers
	req_t                req_q;
	logic [TMO_W-1:0]    tmo_q;
	logic [QW-1:0]       q_est_q;
	logic [MAX_CONN-1:0] id_mask_q;
	logic                id_ok_q;
	logic                slot_ok_q;
	logic [HAND_W-1:0]   slot_addr_q;
	logic [HAND_W-1:0]   target_q;
	logic [HAND_W-1:0]   hand_q;

	logic [MAX_CONN-1:0] rd_a_q;
	logic [MAX_CONN-1:0] rd_b_q;
	logic                va_q;
	logic                vb_q;
	logic [MAX_CONN-1:0] scan_q;

	logic                  out_valid_q;
	logic                  status_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	logic [ID_W-1:0]       expired_id_q;
	logic                  expired_valid_q;
	logic                  last_q;

	logic [HAND_W-1:0]   hand_next;
	logic [PW-1:0]       prod;
	logic [PW-1:0]       diff;
	logic [REM_W-1:0]    rem0;
	logic [REM_W-1:0]    rem1;
	logic [REM_W-1:0]    sum;
	logic [REM_W-1:0]    tgt;
	logic [HAND_W-1:0]   target;
	logic [HAND_W-1:0]   addr_a;
	logic [MAX_CONN-1:0] mem_a;
	logic [MAX_CONN-1:0] mem_b;
	logic                present;
	logic [MAX_CONN-1:0] scan_next;

	logic                  wr_en;
	logic [HAND_W-1:0]     wr_addr;
	logic [MAX_CONN-1:0]   wr_data;
	logic                  clr_en;
	logic                  res_load;
	logic                  res_status;
	logic [SLOT_OUT_W-1:0] res_slot;

	// target slot: (hand + timeout mod W + 1) mod W, quotient estimated at load
	assign hand_next = (hand_q == HAND_W'(WHEEL_SIZE - 1)) ? '0 : hand_q + HAND_W'(1);
	assign prod      = PW'(q_est_q) * PW'(WHEEL_SIZE);
	assign diff      = PW'(tmo_q) - prod;
	assign rem0      = diff[REM_W-1:0];
	assign rem1      = (rem0 >= REM_W'(WHEEL_SIZE)) ? rem0 - REM_W'(WHEEL_SIZE) : rem0;
	assign sum       = rem1 + REM_W'(hand_q) + REM_W'(1);
	assign tgt       = (sum >= REM_W'(WHEEL_SIZE)) ? sum - REM_W'(WHEEL_SIZE) : sum;
	assign target    = tgt[HAND_W-1:0];
	assign addr_a    = (req_q == REQ_TICK) ? hand_next : slot_addr_q;

	assign mem_a     = va_q ? rd_a_q : '0;
	assign mem_b     = vb_q ? rd_b_q : '0;
	assign present   = id_ok_q && slot_ok_q && ((mem_a & id_mask_q) != '0);
	assign scan_next = scan_q & (scan_q - MAX_CONN'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q       <= req_t'(req_type);
			tmo_q       <= timeout_secs;
			q_est_q     <= QW'((32'(timeout_secs) * 32'(RECIP)) >> 16);
			id_mask_q   <= MAX_CONN'(1) << conn_id;
			id_ok_q     <= 32'(conn_id) < 32'(MAX_CONN);
			slot_ok_q   <= 32'(slot_in) < 32'(WHEEL_SIZE);
			slot_addr_q <= HAND_W'(slot_in);
		end
		if (cmd.calc) begin
			target_q <= target;
		end
	end

	// bitmap memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.calc) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[target];
			va_q   <= vld_q[addr_a];
			vb_q   <= vld_q[target];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			hand_q <= '0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			// an invalid slot reads as empty
			if (clr_en) begin
				vld_q[hand_q] <= 1'b0;
			end
			if (cmd.calc && req_q == REQ_TICK) begin
				hand_q <= hand_next;
			end
		end
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = target_q;
		wr_data    = mem_b | id_mask_q;
		clr_en     = 1'b0;
		res_load   = 1'b0;
		res_status = 1'b1;
		res_slot   = SLOT_OUT_W'(WHEEL_SIZE);
		if (cmd.eval) begin
			case (req_q)
				REQ_ADD: begin
					res_load = 1'b1;
					if (id_ok_q) begin
						wr_en      = 1'b1;
						res_status = 1'b0;
						res_slot   = SLOT_OUT_W'(target_q);
					end
				end
				REQ_GET: begin
					res_load = 1'b1;
					if (present) begin
						res_status = 1'b0;
						res_slot   = SLOT_OUT_W'(slot_addr_q);
					end
				end
				REQ_DEL: begin
					res_load = 1'b1;
					if (present) begin
						wr_en      = 1'b1;
						wr_addr    = slot_addr_q;
						wr_data    = mem_a & ~id_mask_q;
						res_status = 1'b0;
						res_slot   = SLOT_OUT_W'(slot_addr_q);
					end
				end
				REQ_UPD: begin
					res_load = 1'b1;
					if (present) begin
						res_status = 1'b0;
						res_slot   = SLOT_OUT_W'(target_q);
						// set in the new slot now, drop from the old one next cycle
						wr_en      = (target_q != slot_addr_q);
					end
				end
				REQ_TICK: begin
					clr_en = 1'b1;
					if (mem_a == '0) begin
						res_load   = 1'b1;
						res_status = 1'b0;
						res_slot   = SLOT_OUT_W'(hand_q);
					end
				end
				default: begin
					res_load = 1'b1;
				end
			endcase
		end
		if (cmd.wr2) begin
			wr_en   = 1'b1;
			wr_addr = slot_addr_q;
			wr_data = mem_a & ~id_mask_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && req_q == REQ_TICK) begin
			scan_q <= mem_a;
		end else if (cmd.emit) begin
			scan_q <= scan_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q        <= res_status;
			slot_out_q      <= res_slot;
			expired_id_q    <= '0;
			expired_valid_q <= 1'b0;
			last_q          <= 1'b1;
		end else if (cmd.emit) begin
			status_q        <= 1'b0;
			slot_out_q      <= SLOT_OUT_W'(hand_q);
			expired_id_q    <= lowest_id(64'(scan_q));
			expired_valid_q <= 1'b1;
			last_q          <= (scan_next == '0);
		end
	end

	assign stat.out_free  = !out_valid_q || rsp_ready;
	assign stat.is_tick   = (req_q == REQ_TICK);
	assign stat.mem_empty = (mem_a == '0);
	assign stat.need_wr2  = (req_q == REQ_UPD) && present && (target_q != slot_addr_q);
	assign stat.scan_last = (scan_next == '0);

	assign rsp_valid     = out_valid_q;
	assign status        = status_q;
	assign slot_out      = slot_out_q;
	assign expired_id    = expired_id_q;
	assign expired_valid = expired_valid_q;
	assign last          = last_q;

endmodule

// ===== design/ctw_checker.sv =====
// ----------------------------------------------------------------------------
// ctw_checker: port-level checks for the connection timing wheel
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module ctw_checker import ctw_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  rsp_status,
	input logic [SLOT_OUT_W-1:0] rsp_slot_out,
	input logic [ID_W-1:0]       rsp_expired_id,
	input logic                  rsp_expired_valid,
	input logic                  rsp_last
);

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
		&& $stable(rsp_slot_out) && $stable(rsp_expired_id)
		&& $stable(rsp_expired_valid) && $stable(rsp_last))
		else $error("stalled response changed");

	// one request at a time: no back-to-back acceptance
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	a_notfound_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_last && !rsp_expired_valid)
		else $error("not-found result is not a single plain result");

	// only a tick scan produces more than one result
	a_multi_expired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_expired_valid && !rsp_status)
		else $error("non-last result without an expired id");

endmodule

bind connection_timing_wheel ctw_checker u_ctw_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_slot_out      (rsp.slot_out),
	.rsp_expired_id    (rsp.expired_id),
	.rsp_expired_valid (rsp.expired_valid),
	.rsp_last          (rsp.last)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for connection_timing_wheel
// Sends add, get, delete, update, tick and unknown requests with random
// gaps on both channels. A local copy of the hand and the slot bitmaps
// predicts every response transaction. Each one is compared field by field
// in order of arrival.
// ----------------------------------------------------------------------------
module tb;
	import ctw_pkg::*;

	localparam int WHEEL        = WHEEL_SIZE_DEF;
	localparam int CONNS        = MAX_CONN_DEF;
	localparam int STALL_MAX    = 10;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_WAIT   = 20;
	localparam int RANDOM_ITEMS = 34;
	localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;

	typedef struct packed {
		logic                  status;
		logic [SLOT_OUT_W-1:0] slot_out;
		logic [ID_W-1:0]       expired_id;
		logic                  expired_valid;
		logic                  last;
	} wheel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ctw_req_if req_bus ();
	ctw_rsp_if rsp_bus ();

	connection_timing_wheel dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	int            wheel_hand = 0;
	logic [CONNS-1:0] slot_bits [WHEEL];
	wheel_result_t pending_results [$];
	int            fail_count = 0;
	int            idle_cycles = 0;
	bit            req_steady = 1'b0;
	bit            rsp_steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_result(logic st, int slot, int id, logic ev, logic lst);
		wheel_result_t r;
		r.status        = st;
		r.slot_out      = SLOT_OUT_W'(slot);
		r.expired_id    = ID_W'(id);
		r.expired_valid = ev;
		r.last          = lst;
		pending_results.push_back(r);
	endfunction

	function automatic void wheel_predict(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
		logic [SLOT_IN_W-1:0] slot, logic [TMO_W-1:0] tmo);
		logic [CONNS-1:0] expired;
		bit id_ok;
		bit slot_ok;
		bit present;
		int dest;
		id_ok   = int'(id) < CONNS;
		slot_ok = int'(slot) < WHEEL;
		present = id_ok && slot_ok && slot_bits[slot][id];
		dest    = (wheel_hand + int'(tmo) + 1) % WHEEL;
		case (kind)
			REQ_TICK: begin
				wheel_hand = (wheel_hand + 1) % WHEEL;
				expired = slot_bits[wheel_hand];
				slot_bits[wheel_hand] = '0;
				if (expired == '0)
					push_result(1'b0, wheel_hand, 0, 1'b0, 1'b1);
				else
					for (int i = 0; i < CONNS; i++)
						if (expired[i])
							push_result(1'b0, wheel_hand, i, 1'b1, (expired >> (i + 1)) == '0);
			end
			REQ_ADD: begin
				if (!id_ok) begin
					push_result(1'b1, WHEEL, 0, 1'b0, 1'b1);
				end else begin
					slot_bits[dest][id] = 1'b1;
					push_result(1'b0, dest, 0, 1'b0, 1'b1);
				end
			end
			REQ_GET, REQ_DEL: begin
				if (!present) begin
					push_result(1'b1, WHEEL, 0, 1'b0, 1'b1);
				end else begin
					if (kind == REQ_DEL)
						slot_bits[slot][id] = 1'b0;
					push_result(1'b0, int'(slot), 0, 1'b0, 1'b1);
				end
			end
			REQ_UPD: begin
				if (!present) begin
					push_result(1'b1, WHEEL, 0, 1'b0, 1'b1);
				end else begin
					// moving onto its own slot leaves the bit set
					if (dest != int'(slot)) begin
						slot_bits[dest][id] = 1'b1;
						slot_bits[slot][id] = 1'b0;
					end
					push_result(1'b0, dest, 0, 1'b0, 1'b1);
				end
			end
			default: begin
				push_result(1'b1, WHEEL, 0, 1'b0, 1'b1);
			end
		endcase
	endfunction

	// Find some id currently held by some slot, starting from random points.
	function automatic bit pick_live_entry(inout logic [ID_W-1:0] id,
		inout logic [SLOT_IN_W-1:0] slot);
		int s0;
		int b0;
		int s;
		int b;
		s0 = $urandom_range(0, WHEEL - 1);
		b0 = $urandom_range(0, CONNS - 1);
		for (int k = 0; k < WHEEL; k++) begin
			s = (s0 + k) % WHEEL;
			if (slot_bits[s] != '0) begin
				for (int j = 0; j < CONNS; j++) begin
					b = (b0 + j) % CONNS;
					if (slot_bits[s][b]) begin
						id   = ID_W'(b);
						slot = SLOT_IN_W'(s);
						return 1'b1;
					end
				end
			end
		end
		return 1'b0;
	endfunction

	task automatic send_request(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
		logic [SLOT_IN_W-1:0] slot, logic [TMO_W-1:0] tmo);
		int gap;
		gap = req_steady ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.req_type     <= kind;
		req_bus.conn_id      <= id;
		req_bus.slot_in      <= slot;
		req_bus.timeout_secs <= tmo;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		wheel_predict(kind, id, slot, tmo);
	endtask

	task automatic test_directed();
		send_request(REQ_TICK, '1, '1, '1);
		send_request(REQ_ADD, 0, 0, 0);
		send_request(REQ_ADD, 63, 0, 16'hFFFF);
		send_request(REQ_ADD, 5, 0, 0);
		send_request(REQ_ADD, 63, 0, 0);
		send_request(REQ_GET, 0, 2, 0);
		send_request(REQ_GET, 1, 2, 0);
		send_request(REQ_GET, 63, 1, 0);
		send_request(REQ_GET, 0, 63, 0);
		send_request(REQ_DEL, 5, 2, 0);
		send_request(REQ_DEL, 5, 2, 0);
		send_request(REQ_UPD, 0, 2, 0);
		send_request(REQ_UPD, 63, 1, 10);
		send_request(REQ_UPD, 63, 12, 16'hFFFF);
		send_request(REQ_UPD, 7, 3, 4);
		for (int k = REQ_UNKNOWN_LO; k <= REQ_UNKNOWN_HI; k++)
			send_request(REQ_W'(k), 0, 2, 0);
		send_request(REQ_TICK, 0, 0, 0);
		send_request(REQ_GET, 63, 1, 0);
		send_request(REQ_TICK, '1, '1, '1);
	endtask

	// Fill the next slot with every id, then expire them all with one tick.
	task automatic test_full_slot();
		logic [TMO_W-1:0] tmo;
		req_steady = 1'b1;
		for (int i = 0; i < CONNS; i++) begin
			tmo = TMO_W'(WHEEL * $urandom_range(0, 1023));
			send_request(REQ_ADD, ID_W'(i), SLOT_IN_W'($urandom), tmo);
		end
		req_steady = 1'b0;
		send_request(REQ_TICK, ID_W'($urandom), SLOT_IN_W'($urandom), TMO_W'($urandom));
	endtask

	task automatic test_random_mix();
		int sent;
		int pick;
		logic [ID_W-1:0]      id;
		logic [SLOT_IN_W-1:0] slot;
		logic [TMO_W-1:0]     tmo;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 20 == 0) begin
				req_steady = ($urandom_range(0, 3) == 0);
				rsp_steady = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			tmo  = ($urandom_range(0, 3) == 0) ? TMO_W'($urandom) : TMO_W'($urandom_range(0, 8));
			id   = ID_W'($urandom);
			slot = SLOT_IN_W'($urandom);
			if (pick < 45) begin
				send_request(REQ_TICK, id, slot, tmo);
			end else if (pick < 70) begin
				send_request(REQ_ADD, id, slot, tmo);
			end else if (pick < 95) begin
				// aim most lookups at a live entry so they hit
				if ($urandom_range(0, 4) != 0)
					void'(pick_live_entry(id, slot));
				case ($urandom_range(0, 2))
					0: send_request(REQ_GET, id, slot, tmo);
					1: send_request(REQ_DEL, id, slot, tmo);
					default: send_request(REQ_UPD, id, slot, tmo);
				endcase
			end else begin
				send_request(REQ_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI)), id, slot, tmo);
			end
			sent++;
		end
		req_steady = 1'b0;
		rsp_steady = 1'b0;
	endtask

	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	initial begin : result_checker
		int stall;
		wheel_result_t want;
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rsp_steady ? 0 : $urandom_range(0, STALL_MAX);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_bus.valid)
				@(posedge clk);
			if (pending_results.size() == 0) begin
				$error("unexpected result: slot_out %0d expired_id %0d expired_valid %0d",
					rsp_bus.slot_out, rsp_bus.expired_id, rsp_bus.expired_valid);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("status", want.status, rsp_bus.status);
				compare_field("slot_out", want.slot_out, rsp_bus.slot_out);
				compare_field("expired_id", want.expired_id, rsp_bus.expired_id);
				compare_field("expired_valid", want.expired_valid, rsp_bus.expired_valid);
				compare_field("last", want.last, rsp_bus.last);
			end
		end
	end

	// End the run if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		req_bus.valid        <= 1'b0;
		req_bus.req_type     <= REQ_ADD;
		req_bus.conn_id      <= '0;
		req_bus.slot_in      <= '0;
		req_bus.timeout_secs <= '0;
		foreach (slot_bits[s])
			slot_bits[s] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_slot();
		test_random_mix();
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
